### rtl/slice_exterior_fill_from_edges_macros.svh
// Assertion macros shared by the slice exterior fill RTL.
`ifndef SLICE_EXTERIOR_FILL_FROM_EDGES_MACROS_SVH
`define SLICE_EXTERIOR_FILL_FROM_EDGES_MACROS_SVH

// Same-cycle implication, sampled on clock, off during reset.
`define SEF_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock, off during reset.
`define SEF_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/sef_pkg.sv
// Types and constants of the slice exterior fill block.
package sef_pkg;

   localparam logic [15:0] FULL_VALUE  = 16'hFFFF;
   localparam logic [15:0] BORDER_VAL  = FULL_VALUE / 16'd2;
   localparam logic [15:0] OUTSIDE_VAL = FULL_VALUE / 16'd4;

   localparam int PIX_W   = 16;
   localparam int COORD_W = 8;
   localparam int DIM_W   = 9;

   typedef enum logic [1:0] {
      OP_WRITE = 2'd0,
      OP_READ  = 2'd1,
      OP_FILL  = 2'd2
   } opcode_type;

   typedef enum logic [0:0] {
      CSR_SLICE_WIDTH  = 1'b0,
      CSR_SLICE_HEIGHT = 1'b1
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ_WAIT,
      ST_FILL,
      ST_PUSH
   } ctl_state_type;

   typedef enum logic [1:0] {
      SQ_IDLE,
      SQ_READ,
      SQ_CHECK
   } seq_state_type;

   typedef enum logic [1:0] {
      PH_ROW_FWD,
      PH_ROW_REV,
      PH_COL_FWD,
      PH_COL_REV
   } phase_type;

   typedef struct packed {
      logic [DIM_W-1:0] width;
      logic [DIM_W-1:0] height;
   } dims_type;

   typedef struct packed {
      logic busy;
      logic done;
   } seq_status_type;

endpackage

### rtl/sef_req_if.sv
// Request channel: one pixel write, pixel read or fill command per beat.
interface sef_req_if
   import sef_pkg::*;
();
   logic               valid;
   logic               ready;
   logic [1:0]         opcode;
   logic [COORD_W-1:0] row;
   logic [COORD_W-1:0] column;
   logic [PIX_W-1:0]   pixel_value;

   modport source (output valid, opcode, row, column, pixel_value, input ready);
   modport sink   (input valid, opcode, row, column, pixel_value, output ready);
endinterface

### rtl/sef_rsp_if.sv
// Response channel: one completion beat per request.
interface sef_rsp_if
   import sef_pkg::*;
();
   logic             valid;
   logic             ready;
   logic [PIX_W-1:0] read_value;
   logic             done_res;

   modport source (output valid, read_value, done_res, input ready);
   modport sink   (input valid, read_value, done_res, output ready);
endinterface

### rtl/sef_ram.sv
// Generic single-port RAM with registered read.
module sef_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 65536
) (
   input  logic                                    clock,
   input  logic                                    en,
   input  logic                                    we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
   input  logic [WIDTH-1:0]                        wdata,
   output logic [WIDTH-1:0]                        rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         if (we) begin
            mem[addr] <= wdata;
         end else begin
            rdata_ff <= mem[addr];
         end
      end
   end

   assign rdata = rdata_ff;
endmodule

### rtl/sef_fill_seq.sv
// Fill sequencer: walks row scans then column scans, reading each pixel, then checking and writing it back.
module sef_fill_seq
   import sef_pkg::*;
#(
   parameter int MAX_WIDTH  = 256,
   parameter int MAX_HEIGHT = 256
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  dims_type         dims,
   output seq_status_type   status,
   output logic             mem_en,
   output logic             mem_we,
   output logic [((MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1)
                 + ((MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1)-1:0] mem_addr,
   output logic [PIX_W-1:0] mem_wdata,
   input  logic [PIX_W-1:0] mem_rdata
);
   localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
   localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int IW = (RW > CW) ? RW : CW;
   localparam int DW = 14;

   seq_state_type state_ff, state_in;
   phase_type     phase_ff, phase_in;
   logic [IW-1:0] outer_ff, outer_in;
   logic [IW-1:0] inner_ff, inner_in;
   logic [IW-1:0] w_last_ff, w_last_in;
   logic [IW-1:0] h_last_ff, h_last_in;
   logic          done_ff, done_in;

   logic [DW-1:0] w_full, h_full, w_eff, h_eff;
   logic          row_phase, fwd_phase, border, scan_end;
   logic [IW-1:0] row_sel, col_sel;

   // Clamp the active area to the store.
   assign w_full = DW'(dims.width);
   assign h_full = DW'(dims.height);
   assign w_eff  = (w_full > DW'(MAX_WIDTH))  ? DW'(MAX_WIDTH)  : w_full;
   assign h_eff  = (h_full > DW'(MAX_HEIGHT)) ? DW'(MAX_HEIGHT) : h_full;

   assign row_phase = (phase_ff == PH_ROW_FWD) || (phase_ff == PH_ROW_REV);
   assign fwd_phase = (phase_ff == PH_ROW_FWD) || (phase_ff == PH_COL_FWD);
   assign row_sel   = row_phase ? outer_ff : inner_ff;
   assign col_sel   = row_phase ? inner_ff : outer_ff;
   assign mem_addr  = {row_sel[RW-1:0], col_sel[CW-1:0]};
   assign mem_wdata = OUTSIDE_VAL;

   assign border   = (mem_rdata == BORDER_VAL);
   assign scan_end = border
                     || (fwd_phase && (inner_ff == (row_phase ? w_last_ff : h_last_ff)))
                     || (!fwd_phase && (inner_ff == '0));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SQ_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      phase_ff  <= phase_in;
      outer_ff  <= outer_in;
      inner_ff  <= inner_in;
      w_last_ff <= w_last_in;
      h_last_ff <= h_last_in;
   end

   always_comb begin
      state_in  = state_ff;
      phase_in  = phase_ff;
      outer_in  = outer_ff;
      inner_in  = inner_ff;
      w_last_in = w_last_ff;
      h_last_in = h_last_ff;
      done_in   = 1'b0;
      mem_en    = 1'b0;
      mem_we    = 1'b0;
      case (state_ff)
         SQ_IDLE: begin
            if (start) begin
               if ((w_eff == '0) || (h_eff == '0)) begin
                  done_in = 1'b1;
               end else begin
                  w_last_in = IW'(w_eff - DW'(1));
                  h_last_in = IW'(h_eff - DW'(1));
                  phase_in  = PH_ROW_FWD;
                  outer_in  = '0;
                  inner_in  = '0;
                  state_in  = SQ_READ;
               end
            end
         end
         SQ_READ: begin
            mem_en   = 1'b1;
            state_in = SQ_CHECK;
         end
         SQ_CHECK: begin
            // Overwrite anything but a border pixel; a border pixel ends the scan.
            mem_en   = !border;
            mem_we   = !border;
            state_in = SQ_READ;
            if (!scan_end) begin
               inner_in = fwd_phase ? inner_ff + IW'(1) : inner_ff - IW'(1);
            end else begin
               case (phase_ff)
                  PH_ROW_FWD: begin
                     phase_in = PH_ROW_REV;
                     inner_in = w_last_ff;
                  end
                  PH_ROW_REV: begin
                     inner_in = '0;
                     if (outer_ff == h_last_ff) begin
                        phase_in = PH_COL_FWD;
                        outer_in = '0;
                     end else begin
                        phase_in = PH_ROW_FWD;
                        outer_in = outer_ff + IW'(1);
                     end
                  end
                  PH_COL_FWD: begin
                     phase_in = PH_COL_REV;
                     inner_in = h_last_ff;
                  end
                  PH_COL_REV: begin
                     inner_in = '0;
                     if (outer_ff == w_last_ff) begin
                        state_in = SQ_IDLE;
                        done_in  = 1'b1;
                     end else begin
                        phase_in = PH_COL_FWD;
                        outer_in = outer_ff + IW'(1);
                     end
                  end
                  default: begin
                     state_in = SQ_IDLE;
                     done_in  = 1'b1;
                  end
               endcase
            end
         end
         default: begin
            state_in = SQ_IDLE;
         end
      endcase
   end

   assign status.busy = (state_ff != SQ_IDLE);
   assign status.done = done_ff;
endmodule

### rtl/slice_exterior_fill_from_edges.sv
// Top level of the slice exterior fill block: request control, slice RAM, response register.
// A pixel write loads the response register directly; a pixel read first registers
// the RAM output. Fill: each visited pixel is read, then checked and written back on
// the single RAM port, over all row and column scans.
// Throughput: one beat per cycle for writes while the response side drains;
// reads and fills hold off the request channel until they finish.
// Reset: synchronous, clears control state and sets both dimensions to 256;
// the slice RAM is not cleared and holds no valid pixel until written.
`include "slice_exterior_fill_from_edges_macros.svh"

module slice_exterior_fill_from_edges
   import sef_pkg::*;
#(
   parameter int MAX_WIDTH  = 256,
   parameter int MAX_HEIGHT = 256
) (
   input  logic             clock,
   input  logic             reset,
   sef_req_if.sink          req_if,
   sef_rsp_if.source        rsp_if,
   input  logic             csr_we,
   input  logic [0:0]       csr_index,
   input  logic [DIM_W-1:0] csr_wdata
);
   localparam int RW    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
   localparam int CW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int AW    = RW + CW;
   localparam int DEPTH = 2 ** AW;
   localparam int XW    = 16;

   // Configuration registers.
   dims_type dims_ff, dims_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         dims_ff <= '{width: DIM_W'(256), height: DIM_W'(256)};
      end else begin
         dims_ff <= dims_in;
      end
   end

   always_comb begin
      dims_in = dims_ff;
      if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_SLICE_WIDTH:  dims_in.width  = csr_wdata;
            CSR_SLICE_HEIGHT: dims_in.height = csr_wdata;
            default: dims_in = dims_ff;
         endcase
      end
   end

   // Request decode: coordinates beyond the store make writes drop and reads return 0.
   logic [XW-1:0] row_wide, col_wide;
   logic          in_store;
   logic [AW-1:0] req_addr;

   assign row_wide = XW'(req_if.row);
   assign col_wide = XW'(req_if.column);
   assign in_store = (row_wide < XW'(MAX_HEIGHT)) && (col_wide < XW'(MAX_WIDTH));
   assign req_addr = {row_wide[RW-1:0], col_wide[CW-1:0]};

   // Fill sequencer and RAM port.
   seq_status_type   seq_status;
   logic             seq_start;
   logic             seq_en, seq_we;
   logic [AW-1:0]    seq_addr;
   logic [PIX_W-1:0] seq_wdata;

   logic             mem_en, mem_we;
   logic [AW-1:0]    mem_addr;
   logic [PIX_W-1:0] mem_wdata, mem_rdata;

   sef_fill_seq #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_fill_seq (
      .clock     (clock),
      .reset     (reset),
      .start     (seq_start),
      .dims      (dims_ff),
      .status    (seq_status),
      .mem_en    (seq_en),
      .mem_we    (seq_we),
      .mem_addr  (seq_addr),
      .mem_wdata (seq_wdata),
      .mem_rdata (mem_rdata)
   );

   sef_ram #(
      .WIDTH (PIX_W),
      .DEPTH (DEPTH)
   ) u_slice_ram (
      .clock (clock),
      .en    (mem_en),
      .we    (mem_we),
      .addr  (mem_addr),
      .wdata (mem_wdata),
      .rdata (mem_rdata)
   );

   // Control state, response register and a one-beat hold for a blocked response.
   ctl_state_type    state_ff, state_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [PIX_W-1:0] rsp_value_ff, rsp_value_in;
   logic [PIX_W-1:0] hold_ff, hold_in;

   logic             req_acc, out_free, res_fire, out_load;
   logic [PIX_W-1:0] res_val;

   assign req_if.ready = (state_ff == ST_IDLE);
   assign req_acc      = req_if.valid && req_if.ready;
   assign out_free     = !rsp_valid_ff || rsp_if.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_value_ff <= rsp_value_in;
      hold_ff      <= hold_in;
   end

   always_comb begin
      state_in  = state_ff;
      mem_en    = 1'b0;
      mem_we    = 1'b0;
      mem_addr  = req_addr;
      mem_wdata = req_if.pixel_value;
      seq_start = 1'b0;
      res_fire  = 1'b0;
      res_val   = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               case (opcode_type'(req_if.opcode))
                  OP_WRITE: begin
                     mem_en   = in_store;
                     mem_we   = in_store;
                     res_fire = 1'b1;
                  end
                  OP_READ: begin
                     if (in_store) begin
                        mem_en   = 1'b1;
                        state_in = ST_READ_WAIT;
                     end else begin
                        res_fire = 1'b1;
                     end
                  end
                  OP_FILL: begin
                     seq_start = 1'b1;
                     state_in  = ST_FILL;
                  end
                  default: begin
                     res_fire = 1'b1;
                  end
               endcase
            end
         end
         ST_READ_WAIT: begin
            res_fire = 1'b1;
            res_val  = mem_rdata;
            state_in = ST_IDLE;
         end
         ST_FILL: begin
            // Hand the RAM port to the sequencer until it reports done.
            mem_en    = seq_en;
            mem_we    = seq_we;
            mem_addr  = seq_addr;
            mem_wdata = seq_wdata;
            if (seq_status.done) begin
               res_fire = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_PUSH: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      // Park a finished response when the output register is still full.
      if (res_fire && !out_free) begin
         state_in = ST_PUSH;
      end
   end

   assign out_load     = out_free && (res_fire || (state_ff == ST_PUSH));
   assign hold_in      = (res_fire && !out_free) ? res_val : hold_ff;
   assign rsp_value_in = out_load ? ((state_ff == ST_PUSH) ? hold_ff : res_val) : rsp_value_ff;
   assign rsp_valid_in = out_load || (rsp_valid_ff && !rsp_if.ready);

   assign rsp_if.valid      = rsp_valid_ff;
   assign rsp_if.read_value = rsp_value_ff;
   assign rsp_if.done_res   = 1'b1;

   `SEF_ASSERT_NOW(a_seq_busy_in_fill, seq_status.busy, state_ff == ST_FILL, "sequencer busy outside fill")
   `SEF_ASSERT_NOW(a_seq_done_in_fill, seq_status.done, state_ff == ST_FILL, "sequencer done outside fill")
   `SEF_ASSERT_NOW(a_fill_writes_outside, (state_ff == ST_FILL) && mem_we, mem_wdata == OUTSIDE_VAL, "fill wrote a value other than outside")
   `SEF_ASSERT_NEXT(a_read_wait_one_cycle, state_ff == ST_READ_WAIT, state_ff != ST_READ_WAIT, "read wait lasted more than one cycle")
endmodule
